### sv/ftc_pkg.sv
// Package for the framebuffer text console: geometry constants, function codes and
// register indexes. No dependencies.
`default_nettype none
package ftc_pkg;
    localparam int FB_WIDTH_DEF   = 256;
    localparam int FB_HEIGHT_DEF  = 128;
    localparam int FONT_CHARS_DEF = 128;
    localparam int GLYPH_W        = 8;
    localparam int GLYPH_H        = 8;
    localparam int COLOR_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [2:0] {
        FN_PUTC   = 3'd0,
        FN_CLEAR  = 3'd1,
        FN_SCROLL = 3'd2,
        FN_PIXEL  = 3'd3,
        FN_GLYPH  = 3'd4,
        FN_FONT   = 3'd5,
        FN_READ   = 3'd6,
        FN_NONE   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        REG_FG     = 2'd0,
        REG_BG     = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;
endpackage
`default_nettype wire

### sv/ftc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ftc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/framebuffer_text_console_unit.sv
// Top level of the framebuffer text console: sequencer, cursor, frame and font stores.
// Uses ftc_pkg and ftc_ram.
//
//  channel | handshake        | payload
//  --------+------------------+--------------------------------------------------
//  in      | in_valid/stall   | func, char_code, pos_x, pos_y, color, font_row, font_bits
//  out     | out_valid/stall  | read_data, cursor_column, cursor_line
//  cfg     | cfg_we           | cfg_index, cfg_data
//
// Put pixel and font load pass S_DISP and S_DONE; read pixel adds S_RWAIT. A glyph draws
// eight font rows, each a fetch, a wait and eight pixel writes through the frame store write port.
// Scroll moves each active-area pixel up by a read then a write on the one port pair, plus
// one step per row, then fills the freed rows with background; clear writes one pixel a
// cycle. A newline that scrolls also runs the scroll. No reset pass: the stores need none.
// in_stall is high while a request is being worked or its result waits; out_stall holds it.
`default_nettype none
module framebuffer_text_console_unit
    import ftc_pkg::*;
#(
    parameter int FB_WIDTH   = FB_WIDTH_DEF,
    parameter int FB_HEIGHT  = FB_HEIGHT_DEF,
    parameter int FONT_CHARS = FONT_CHARS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            func,
    input  wire logic [7:0]            char_code,
    input  wire logic [7:0]            pos_x,
    input  wire logic [6:0]            pos_y,
    input  wire logic [31:0]           color,
    input  wire logic [2:0]            font_row,
    input  wire logic [7:0]            font_bits,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [31:0]                read_data,
    output logic [4:0]                 cursor_column,
    output logic [3:0]                 cursor_line,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int XW = $clog2(FB_WIDTH);
    localparam int YW = $clog2(FB_HEIGHT);
    localparam int CW = (FB_WIDTH > 256 ? 9 : XW) + 1;   // room for clamped width
    localparam int HW = (FB_HEIGHT > 128 ? 8 : YW) + 1;
    localparam int AW = XW + YW;
    localparam int FB_DEPTH = 1 << AW;
    localparam int FONT_DEPTH = FONT_CHARS * GLYPH_H;
    localparam int FAW = $clog2(FONT_DEPTH) > 0 ? $clog2(FONT_DEPTH) : 1;
    localparam int GW  = FONT_CHARS > 1 ? $clog2(FONT_CHARS) : 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DISP   = 10'b0000000010,
        S_GFETCH = 10'b0000000100,
        S_GWAIT  = 10'b0000001000,
        S_GDRAW  = 10'b0000010000,
        S_SREAD  = 10'b0000100000,
        S_SCOPY  = 10'b0001000000,
        S_FILL   = 10'b0010000000,
        S_RWAIT  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] fg_reg, bg_reg;
    logic [8:0]  aw_reg;
    logic [7:0]  ah_reg;
    logic [4:0]  col_reg, col_next;
    logic [3:0]  row_reg, row_next;

    logic [2:0]  func_reg;
    logic [7:0]  code_reg;
    logic [7:0]  px_reg;
    logic [6:0]  py_reg;
    logic [31:0] color_reg;
    logic [2:0]  frow_reg;
    logic [7:0]  fbits_reg;
    logic [31:0] rd_reg, rd_next;
    logic        ovalid_reg, ovalid_next;
    logic        home_reg, home_next;  // clear homes cursor

    // result held for the output side
    logic [31:0] res_rd_reg, res_rd_next;
    logic [4:0]  res_col_reg, res_col_next;
    logic [3:0]  res_row_reg, res_row_next;

    // walk counters
    logic [CW-1:0] wx_reg, wx_next;
    logic [HW-1:0] wy_reg, wy_next;
    logic [2:0]    gx_reg, gx_next;
    logic [2:0]    gy_reg, gy_next;
    logic [7:0]    gbits_reg, gbits_next;

    // effective area
    logic [CW-1:0] ew;
    logic [HW-1:0] eh;
    logic [5:0]    cols;
    logic [4:0]    rows;

    always_comb
    begin
        ew = (32'(aw_reg) < 32'(FB_WIDTH)) ? CW'(aw_reg) : CW'(FB_WIDTH);
        eh = (32'(ah_reg) < 32'(FB_HEIGHT)) ? HW'(ah_reg) : HW'(FB_HEIGHT);
        cols = 6'((32'(ew) >> 3) > 32 ? 32 : (32'(ew) >> 3));
        rows = 5'((32'(eh) >> 3) > 16 ? 16 : (32'(eh) >> 3));
    end

    // frame store
    logic           fb_we;
    logic [AW-1:0]  fb_waddr, fb_raddr;
    logic [31:0]    fb_wdata, fb_rdata;

    ftc_ram #(.WIDTH(COLOR_W), .DEPTH(FB_DEPTH)) u_frame (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    // font store
    logic           ft_we;
    logic [FAW-1:0] ft_waddr, ft_raddr;
    logic [7:0]     ft_rdata;

    ftc_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
        .clk   (clk),
        .we    (ft_we),
        .waddr (ft_waddr),
        .wdata (fbits_reg),
        .raddr (ft_raddr),
        .rdata (ft_rdata)
    );

    logic          accept;
    logic [GW-1:0] glyph;
    logic [31:0]   gpx, gpy;     // glyph pixel coordinates
    logic [4:0]    gcol;
    logic [3:0]    grow;
    logic          scroll_ok;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign read_data = res_rd_reg;
    assign cursor_column = res_col_reg;
    assign cursor_line   = res_row_reg;
    assign scroll_ok = (32'(eh) > 32'(GLYPH_H));

    always_comb
    begin
        glyph = (32'(code_reg) < 32'(FONT_CHARS)) ? GW'(code_reg) : '0;
        gcol  = (func_t'(func_reg) == FN_GLYPH) ? px_reg[4:0] : col_reg;
        grow  = (func_t'(func_reg) == FN_GLYPH) ? py_reg[3:0] : row_reg;
        if (func_t'(func_reg) == FN_GLYPH)
        begin
            gpx = 32'(px_reg) * 32'(GLYPH_W) + 32'(gx_reg);
            gpy = 32'(py_reg) * 32'(GLYPH_H) + 32'(gy_reg);
        end
        else
        begin
            gpx = {24'd0, gcol, gx_reg};
            gpy = {25'd0, grow, gy_reg};
        end
        ft_raddr = FAW'(32'(glyph) * 32'(GLYPH_H) + 32'(gy_reg));
    end

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rd_next     = rd_reg;
        ovalid_next = ovalid_reg;
        home_next   = home_reg;
        res_rd_next  = res_rd_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        wx_next     = wx_reg;
        wy_next     = wy_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        gbits_next  = gbits_reg;
        fb_we       = 1'b0;
        fb_waddr    = '0;
        fb_wdata    = bg_reg;
        fb_raddr    = AW'(px_reg) | (AW'(py_reg) << XW);
        ft_we       = 1'b0;
        ft_waddr    = FAW'(32'(code_reg) * 32'(GLYPH_H) + 32'(frow_reg));

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                rd_next = '0;
                wx_next = '0;
                wy_next = '0;
                gx_next = '0;
                gy_next = '0;
                home_next = 1'b0;
                state_next = S_DONE;
                unique case (func_t'(func_reg))
                    FN_PUTC:
                    begin
                        if (code_reg == NEWLINE_CODE)
                        begin
                            col_next = '0;
                            if (32'(row_reg) + 1 >= 32'(rows))
                            begin
                                if (scroll_ok)
                                    state_next = S_SREAD;
                            end
                            else
                                row_next = row_reg + 4'd1;
                        end
                        else
                            state_next = S_GFETCH;
                    end
                    FN_GLYPH:  state_next = S_GFETCH;
                    FN_CLEAR:
                    begin
                        home_next  = 1'b1;
                        state_next = S_FILL;
                    end
                    FN_SCROLL:
                    begin
                        if (scroll_ok)
                            state_next = S_SREAD;
                    end
                    FN_PIXEL:
                    begin
                        if (32'(px_reg) < 32'(ew) && 32'(py_reg) < 32'(eh))
                        begin
                            fb_we    = 1'b1;
                            fb_waddr = AW'(px_reg) | (AW'(py_reg) << XW);
                            fb_wdata = color_reg;
                        end
                    end
                    FN_FONT:
                    begin
                        ft_we = (32'(code_reg) < 32'(FONT_CHARS));
                    end
                    FN_READ:   state_next = S_RWAIT;
                    FN_NONE:   state_next = S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_RWAIT:
            begin
                // read address held from S_DISP; data now registered
                if (32'(px_reg) < 32'(ew) && 32'(py_reg) < 32'(eh))
                    rd_next = fb_rdata;
                state_next = S_DONE;
            end
            S_GFETCH:
            begin
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                gbits_next = ft_rdata;
                state_next = S_GDRAW;
            end
            S_GDRAW:
            begin
                if (gpx < 32'(ew) && gpy < 32'(eh))
                begin
                    fb_we    = 1'b1;
                    fb_waddr = AW'(gpx) | AW'(gpy << XW);
                    fb_wdata = gbits_reg[gx_reg] ? fg_reg : bg_reg;
                end
                gx_next = gx_reg + 3'd1;
                if (gx_reg == 3'd7)
                begin
                    gy_next = gy_reg + 3'd1;
                    if (gy_reg == 3'd7)
                    begin
                        state_next = S_DONE;
                        if (func_t'(func_reg) == FN_PUTC)
                        begin
                            if (32'(col_reg) + 1 >= 32'(cols) || col_reg == 5'd31)
                            begin
                                col_next = '0;
                                if (32'(row_reg) + 1 >= 32'(rows))
                                begin
                                    if (scroll_ok)
                                    begin
                                        wx_next = '0;
                                        wy_next = '0;
                                        state_next = S_SREAD;
                                    end
                                end
                                else
                                    row_next = row_reg + 4'd1;
                            end
                            else
                                col_next = col_reg + 5'd1;
                        end
                    end
                    else
                        state_next = S_GFETCH;
                end
            end
            S_SREAD:
            begin
                // read source pixel 8 rows below
                if (wx_reg >= ew)
                begin
                    wx_next = '0;
                    wy_next = wy_reg + HW'(1);
                    if (32'(wy_reg) + 1 >= 32'(eh) - GLYPH_H)
                    begin
                        wy_next = HW'(32'(eh) - GLYPH_H);
                        state_next = S_FILL;
                    end
                end
                else
                begin
                    fb_raddr = AW'(wx_reg) | AW'((32'(wy_reg) + GLYPH_H) << XW);
                    state_next = S_SCOPY;
                end
            end
            S_SCOPY:
            begin
                fb_we    = 1'b1;
                fb_waddr = AW'(wx_reg) | AW'(32'(wy_reg) << XW);
                fb_wdata = fb_rdata;
                wx_next  = wx_reg + CW'(1);
                state_next = S_SREAD;
            end
            S_FILL:
            begin
                if (wy_reg >= eh || ew == '0)
                begin
                    if (home_reg)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    fb_we    = 1'b1;
                    fb_waddr = AW'(wx_reg) | AW'(32'(wy_reg) << XW);
                    fb_wdata = bg_reg;
                    if (wx_reg + CW'(1) >= ew)
                    begin
                        wx_next = '0;
                        wy_next = wy_reg + HW'(1);
                    end
                    else
                        wx_next = wx_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next  = 1'b1;
                    res_rd_next  = rd_reg;
                    res_col_next = col_reg;
                    res_row_next = row_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fg_reg     <= 32'h00FF_FFFF;
            bg_reg     <= '0;
            aw_reg     <= 9'd256;
            ah_reg     <= 8'd128;
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_FG:     fg_reg <= cfg_data;
                    REG_BG:     bg_reg <= cfg_data;
                    REG_WIDTH:  aw_reg <= cfg_data[8:0];
                    REG_HEIGHT: ah_reg <= cfg_data[7:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            code_reg  <= char_code;
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            color_reg <= color;
            frow_reg  <= font_row;
            fbits_reg <= font_bits;
        end
        rd_reg      <= rd_next;
        home_reg    <= home_next;
        res_rd_reg  <= res_rd_next;
        res_col_reg <= res_col_next;
        res_row_reg <= res_row_next;
        wx_reg      <= wx_next;
        wy_reg      <= wy_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        gbits_reg   <= gbits_next;
    end
endmodule
`default_nettype wire

### dv/framebuffer_text_console_unit_tb.sv
// Self-checking testbench for framebuffer_text_console_unit: a directed table, then random
// requests over several register settings, checked against a local console predictor or typed values.
// Depends on ftc_pkg and the RTL of the block.
module framebuffer_text_console_unit_tb;
    import ftc_pkg::*;

    localparam int STORE_W  = 256;
    localparam int STORE_H  = 128;
    localparam int QUIET_MAX = 400000;

    typedef struct {
        func_t       fn;
        logic [7:0]  code;
        logic [7:0]  x;
        logic [6:0]  y;
        logic [31:0] colour;
        logic [2:0]  frow;
        logic [7:0]  fbits;
    } req_t;

    typedef struct {
        logic [31:0] rd;
        logic [4:0]  col;
        logic [3:0]  line;
    } res_t;

    typedef struct {
        req_t r;
        bit   typed;
        res_t t;
    } row_t;

    typedef struct {
        logic [31:0] fg;
        logic [31:0] bg;
        logic [8:0]  w;
        logic [7:0]  h;
        int          n;
        bit          quiet;
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [7:0]  char_code = '0;
    logic [7:0]  pos_x = '0;
    logic [6:0]  pos_y = '0;
    logic [31:0] color = '0;
    logic [2:0]  font_row = '0;
    logic [7:0]  font_bits = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic [4:0]  cursor_column;
    logic [3:0]  cursor_line;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    framebuffer_text_console_unit dut (.*);

    always #6 clk = ~clk;

    // console state as the block should hold it
    logic [31:0] pix [STORE_W*STORE_H];
    logic [7:0]  glyph_rows [FONT_CHARS_DEF*GLYPH_H];
    bit          row_loaded [FONT_CHARS_DEF][GLYPH_H];
    int          ready_codes[$];
    int          col_pos, row_pos;
    logic [31:0] fg_c, bg_c;
    int          act_w, act_h;

    res_t        expected_results[$];
    int          fails = 0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;

    function automatic int area_w();
        return act_w < STORE_W ? act_w : STORE_W;
    endfunction

    function automatic int area_h();
        return act_h < STORE_H ? act_h : STORE_H;
    endfunction

    function automatic void plot(int x, int y, logic [31:0] v);
        if (x < area_w() && y < area_h())
            pix[y*STORE_W + x] = v;
    endfunction

    function automatic void draw_cell(int c, int r, int code);
        int g;
        logic [7:0] bits;
        g = code < FONT_CHARS_DEF ? code : 0;
        for (int gy = 0; gy < GLYPH_H; gy++)
        begin
            bits = glyph_rows[g*GLYPH_H + gy];
            for (int gx = 0; gx < GLYPH_W; gx++)
                plot(c*GLYPH_W + gx, r*GLYPH_H + gy, bits[gx] ? fg_c : bg_c);
        end
    endfunction

    function automatic void scroll_up();
        int w, h;
        w = area_w();
        h = area_h();
        if (h <= GLYPH_H)
            return;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                pix[y*STORE_W + x] = (y < h - GLYPH_H) ? pix[(y+GLYPH_H)*STORE_W + x] : bg_c;
    endfunction

    function automatic void next_line();
        col_pos = 0;
        if (row_pos + 1 >= area_h() / GLYPH_H || row_pos + 1 > 15)
            scroll_up();
        else
            row_pos++;
    endfunction

    function automatic res_t console_model(req_t r);
        res_t o;
        o.rd = '0;
        case (r.fn)
            FN_PUTC:
                if (r.code == NEWLINE_CODE)
                    next_line();
                else
                begin
                    draw_cell(col_pos, row_pos, r.code);
                    col_pos++;
                    if (col_pos >= area_w() / GLYPH_W || col_pos > 31)
                        next_line();
                end
            FN_CLEAR:
            begin
                for (int y = 0; y < area_h(); y++)
                    for (int x = 0; x < area_w(); x++)
                        pix[y*STORE_W + x] = bg_c;
                col_pos = 0;
                row_pos = 0;
            end
            FN_SCROLL: scroll_up();
            FN_PIXEL:  plot(r.x, r.y, r.colour);
            FN_GLYPH:  draw_cell(r.x, r.y, r.code);
            FN_FONT:
                if (r.code < FONT_CHARS_DEF)
                begin
                    glyph_rows[r.code*GLYPH_H + r.frow] = r.fbits;
                    if (!row_loaded[r.code][r.frow])
                    begin
                        row_loaded[r.code][r.frow] = 1'b1;
                        if (row_loaded[r.code].and() == 1'b1)
                            ready_codes.push_back(r.code);
                    end
                end
            FN_READ:
                if (r.x < area_w() && r.y < area_h())
                    o.rd = pix[r.y*STORE_W + r.x];
            default: ;
        endcase
        o.col  = col_pos[4:0];
        o.line = row_pos[3:0];
        return o;
    endfunction

    task automatic send_req(input req_t r, input bit typed, input res_t t);
        res_t p;
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= r.fn;
        char_code <= r.code;
        pos_x     <= r.x;
        pos_y     <= r.y;
        color     <= r.colour;
        font_row  <= r.frow;
        font_bits <= r.fbits;
        do
            @(posedge clk);
        while (in_stall);
        p = console_model(r);
        expected_results.push_back(typed ? t : p);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FG:     fg_c = v;
            REG_BG:     bg_c = v;
            REG_WIDTH:  act_w = int'(v[8:0]);
            REG_HEIGHT: act_h = int'(v[7:0]);
            default: ;
        endcase
    endtask

    function automatic req_t blank_req(func_t f);
        req_t r;
        r.fn = f;
        r.code = 8'($urandom_range(255));
        r.x = 8'($urandom_range(255));
        r.y = 7'($urandom_range(127));
        r.colour = $urandom;
        r.frow = 3'($urandom_range(7));
        r.fbits = 8'($urandom_range(255));
        return r;
    endfunction

    // a code whose glyph rows are all loaded, or a high code, which falls back to glyph 0
    function automatic logic [7:0] drawable_code();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(128, 255));
        return 8'(ready_codes[$urandom_range(ready_codes.size() - 1)]);
    endfunction

    task automatic random_req();
        req_t r;
        res_t none;
        int   pick;
        none = '{default: '0};
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            r = blank_req(FN_PUTC);
            r.code = ($urandom_range(4) == 0) ? NEWLINE_CODE : drawable_code();
        end
        else if (pick < 50)
        begin
            r = blank_req(FN_GLYPH);
            r.code = drawable_code();
            if ($urandom_range(1))
            begin
                r.x = 8'($urandom_range(area_w() / GLYPH_W + 1));
                r.y = 7'($urandom_range(area_h() / GLYPH_H + 1));
            end
        end
        else if (pick < 62)
            r = blank_req(FN_PIXEL);
        else if (pick < 78)
            r = blank_req(FN_READ);
        else if (pick < 84)
        begin
            // whole glyph, row by row
            r = blank_req(FN_FONT);
            r.code = 8'($urandom_range(127));
            for (int i = 0; i < GLYPH_H - 1; i++)
            begin
                r.frow = 3'(i);
                r.fbits = 8'($urandom_range(255));
                send_req(r, 1'b0, none);
            end
            r.frow = 3'(GLYPH_H - 1);
            r.fbits = 8'($urandom_range(255));
        end
        else if (pick < 90)
            r = blank_req(FN_FONT);
        else if (pick < 93)
            r = blank_req(FN_CLEAR);
        else if (pick < 97)
            r = blank_req(FN_SCROLL);
        else
            r = blank_req(FN_NONE);
        send_req(r, 1'b0, none);
    endtask

    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 6);

    always @(posedge clk)
    begin
        res_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing outstanding");
                fails++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (read_data !== e.rd)
                begin
                    $error("read_data: expected %h, got %h", e.rd, read_data);
                    fails++;
                end
                if (cursor_column !== e.col)
                begin
                    $error("cursor_column: expected %0d, got %0d", e.col, cursor_column);
                    fails++;
                end
                if (cursor_line !== e.line)
                begin
                    $error("cursor_line: expected %0d, got %0d", e.line, cursor_line);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > QUIET_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        row_t   dir[$];
        phase_t phases[$];
        res_t   none;
        req_t   r;

        none = '{default: '0};
        fg_c = 32'h00FF_FFFF;
        bg_c = '0;
        act_w = 256;
        act_h = 128;
        col_pos = 0;
        row_pos = 0;
        foreach (pix[i]) pix[i] = '0;
        foreach (glyph_rows[i]) glyph_rows[i] = '0;

        // directed: clear the whole store first so every later read sees written pixels
        r = blank_req(FN_CLEAR);
        dir.push_back('{r, 1'b1, '{32'h0, 5'd0, 4'd0}});
        for (int i = 0; i < GLYPH_H; i++)
        begin
            r = blank_req(FN_FONT);
            r.code = 8'd0;
            r.frow = 3'(i);
            r.fbits = (i == 0) ? 8'hFF : (i == 7) ? 8'h00 : 8'(1 << i);
            dir.push_back('{r, 1'b0, none});
        end
        r = blank_req(FN_FONT);   r.code = 8'd255;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_PUTC);   r.code = 8'd128;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_PUTC);   r.code = NEWLINE_CODE;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_PIXEL);  r.x = 8'd255; r.y = 7'd127; r.colour = 32'hFFFF_FFFF;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_READ);   r.x = 8'd255; r.y = 7'd127;
        dir.push_back('{r, 1'b1, '{32'hFFFF_FFFF, 5'd0, 4'd1}});
        r = blank_req(FN_PIXEL);  r.x = 8'd0; r.y = 7'd0; r.colour = 32'h0;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_READ);   r.x = 8'd0; r.y = 7'd0;
        dir.push_back('{r, 1'b1, '{32'h0, 5'd0, 4'd1}});
        r = blank_req(FN_GLYPH);  r.code = 8'd128; r.x = 8'd31; r.y = 7'd15;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_GLYPH);  r.code = 8'd0; r.x = 8'd255; r.y = 7'd127;
        dir.push_back('{r, 1'b0, none});
        r = blank_req(FN_NONE);
        dir.push_back('{r, 1'b1, '{32'h0, 5'd0, 4'd1}});
        r = blank_req(FN_SCROLL);
        dir.push_back('{r, 1'b0, none});

        phases.push_back('{32'h00FF_FFFF, 32'h0, 9'd256, 8'd128, 30, 1'b0});
        phases.push_back('{$urandom, $urandom, 9'd64, 8'd32, 210, 1'b0});
        phases.push_back('{32'h0, 32'hFFFF_FFFF, 9'd0, 8'd0, 70, 1'b0});
        phases.push_back('{32'hFFFF_FFFF, 32'h0, 9'd511, 8'd255, 30, 1'b0});
        phases.push_back('{$urandom, $urandom, 9'd24, 8'd16, 210, 1'b1});
        phases.push_back('{$urandom, $urandom, 9'd256, 8'd8, 100, 1'b0});
        phases.push_back('{$urandom, $urandom, 9'd8, 8'd128, 100, 1'b0});
        phases.push_back('{$urandom, $urandom, 9'd100, 8'd50, 116, 1'b0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir[i])
            send_req(dir[i].r, dir[i].typed, dir[i].t);

        foreach (phases[p])
        begin
            drain();
            if (p != 0)
            begin
                write_reg(REG_FG, phases[p].fg);
                write_reg(REG_BG, phases[p].bg);
                write_reg(REG_WIDTH, 32'(phases[p].w));
                write_reg(REG_HEIGHT, 32'(phases[p].h));
            end
            quiet = phases[p].quiet;
            repeat (phases[p].n) random_req();
        end
        quiet = 1'b0;
        drain();

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### sim.f
sv/ftc_pkg.sv
sv/ftc_ram.sv
sv/framebuffer_text_console_unit.sv
dv/framebuffer_text_console_unit_tb.sv
